[hdl/block_buffer_cache_manager_top_defines.svh]
// assertion macros for the block buffer cache manager checker
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef BLOCK_BUFFER_CACHE_MANAGER_TOP_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_MANAGER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BBCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbcm check failed");

// next-cycle implication, disabled during reset
`define BBCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbcm check failed");

`endif

[hdl/bbcm_pkg.sv]
// shared constants, codes and control types of the block buffer cache manager
// no dependencies
package bbcm_pkg;

    localparam int SLOT_COUNT       = 32;
    localparam int DISK_BLOCK_COUNT = 8192;
    localparam int AGE_BITS         = 16;

    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int BLOCK_W   = $clog2(DISK_BLOCK_COUNT);
    localparam int BLK_IN_W  = 16;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int LEAVES    = 1 << SLOT_W;
    localparam int SCAN_CNT_W = $clog2(SLOT_W + 1);

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIRTY  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOB  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load_req;
        logic res_oob;
        logic res_find;
        logic age_inc;
        logic claim_free;
        logic claim_victim;
        logic push_rsp;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              oob;
        logic              any_free;
        logic              rsp_free;
    } sts_t;

endpackage

[hdl/bbcm_if.sv]
// request and response channel interfaces of the block buffer cache manager
// depends on bbcm_pkg
interface bbcm_req_if import bbcm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [BLK_IN_W-1:0] block_num;

    modport source (output valid, output kind, output block_num, input ready);
    modport sink   (input valid, input kind, input block_num, output ready);
endinterface

interface bbcm_rsp_if import bbcm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic                writeback_valid;
    logic [BLOCK_W-1:0]  writeback_block;

    modport source (output valid, output status, output slot_index,
                    output writeback_valid, output writeback_block, input ready);
    modport sink   (input valid, input status, input slot_index,
                    input writeback_valid, input writeback_block, output ready);
endinterface

[hdl/bbcm_ctrl.sv]
// controller state machine of the block buffer cache manager
// depends on bbcm_pkg; drives cmd_t to bbcm_datapath, reads sts_t
module bbcm_ctrl import bbcm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_PICK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_CLAIM = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [SCAN_CNT_W-1:0] cnt_reg;
    logic [SCAN_CNT_W-1:0] cnt_next;

    // state and scan counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.kind == KIND_NONE)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.oob)
                begin
                    cmd.res_oob = 1'b1;
                    state_next  = S_RESP;
                end
                else if (sts.kind == KIND_ALLOC)
                begin
                    cmd.age_inc = 1'b1;
                    state_next  = S_PICK;
                end
                else
                begin
                    cmd.res_find = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_PICK:
            begin
                if (sts.any_free)
                begin
                    cmd.claim_free = 1'b1;
                    state_next     = S_RESP;
                end
                else
                begin
                    // give the victim tree time to settle on the new ages
                    cnt_next   = SCAN_CNT_W'(SLOT_W - 1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_CLAIM;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_CLAIM:
            begin
                cmd.claim_victim = 1'b1;
                state_next       = S_RESP;
            end
            S_RESP:
            begin
                if (sts.rsp_free)
                begin
                    cmd.push_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/bbcm_datapath.sv]
// slot directory datapath: used, dirty, age and block arrays, lookup,
// free search, registered victim tree and response register
// depends on bbcm_pkg; controlled by bbcm_ctrl through cmd_t and sts_t
module bbcm_datapath import bbcm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [KIND_W-1:0]   req_kind,
    input  logic [BLK_IN_W-1:0] req_block_num,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output logic [STATUS_W-1:0] rsp_status,
    output logic [SLOT_W-1:0]   rsp_slot_index,
    output logic                rsp_writeback_valid,
    output logic [BLOCK_W-1:0]  rsp_writeback_block
);

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    // request registers
    logic [KIND_W-1:0]   kind_reg;
    logic [BLK_IN_W-1:0] block_reg;

    // slot directory
    logic [SLOT_COUNT-1:0] slot_used_reg;
    logic [SLOT_COUNT-1:0] slot_dirty_reg;
    logic [AGE_BITS-1:0]   slot_age_reg   [SLOT_COUNT];
    logic [BLOCK_W-1:0]    slot_block_reg [SLOT_COUNT];

    // result registers
    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                res_wb_valid_reg;
    logic [BLOCK_W-1:0]  res_wb_block_reg;

    // response register
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [SLOT_W-1:0]   rsp_slot_reg;
    logic                rsp_wb_valid_reg;
    logic [BLOCK_W-1:0]  rsp_wb_block_reg;

    // victim tree nodes
    logic [AGE_BITS-1:0] node_age_reg [1:LEAVES-1];
    logic [SLOT_W-1:0]   node_idx_reg [1:LEAVES-1];
    logic                node_ok_reg  [1:LEAVES-1];
    logic [AGE_BITS-1:0] tree_age [1:2*LEAVES-1];
    logic [SLOT_W-1:0]   tree_idx [1:2*LEAVES-1];
    logic                tree_ok  [1:2*LEAVES-1];

    logic [BLOCK_W-1:0]  req_blk;
    logic [SLOT_COUNT-1:0] hit_vec;
    logic                hit_any;
    logic [SLOT_W-1:0]   hit_idx;
    logic [SLOT_W-1:0]   free_idx;
    logic [SLOT_W-1:0]   root_idx;
    logic [SLOT_W-1:0]   claim_idx;
    logic                claim;
    logic                victim_dirty;

    assign req_blk   = block_reg[BLOCK_W-1:0];
    assign root_idx  = node_idx_reg[1];
    assign claim     = cmd.claim_free | cmd.claim_victim;
    assign claim_idx = cmd.claim_free ? free_idx : root_idx;
    assign victim_dirty = slot_dirty_reg[root_idx];

    // status to controller
    assign sts.kind     = kind_reg;
    assign sts.oob      = {1'b0, block_reg} >= (BLK_IN_W + 1)'(DISK_BLOCK_COUNT);
    assign sts.any_free = ~&slot_used_reg;
    assign sts.rsp_free = ~rsp_valid_reg | rsp_ready;

    // block match and lowest-index priority encoders
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            hit_vec[i] = slot_used_reg[i] && (slot_block_reg[i] == req_blk);
            if (hit_vec[i])
            begin
                hit_idx = SLOT_W'(i);
            end
            if (!slot_used_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign hit_any = |hit_vec;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            kind_reg  <= req_kind;
            block_reg <= req_block_num;
        end
    end

    // used and dirty flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg  <= '0;
            slot_dirty_reg <= '0;
        end
        else if (claim)
        begin
            slot_used_reg[claim_idx]  <= 1'b1;
            slot_dirty_reg[claim_idx] <= 1'b0;
        end
        else if (cmd.res_find && hit_any && kind_reg == KIND_DIRTY)
        begin
            slot_dirty_reg[hit_idx] <= 1'b1;
        end
    end

    // ages: saturating increment of used slots, cleared on claim
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_age_reg[i] <= '0;
            end
        end
        else if (cmd.age_inc)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (slot_used_reg[i] && slot_age_reg[i] != AGE_MAX)
                begin
                    slot_age_reg[i] <= slot_age_reg[i] + 1'b1;
                end
            end
        end
        else if (claim)
        begin
            slot_age_reg[claim_idx] <= '0;
        end
    end

    // block numbers, written on claim
    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            slot_block_reg[claim_idx] <= req_blk;
        end
    end

    // tree leaves and node views; padding leaves never win
    for (genvar n = 1; n < LEAVES; n++)
    begin : g_node_view
        assign tree_age[n] = node_age_reg[n];
        assign tree_idx[n] = node_idx_reg[n];
        assign tree_ok[n]  = node_ok_reg[n];
    end

    for (genvar i = 0; i < LEAVES; i++)
    begin : g_leaf
        if (i < SLOT_COUNT)
        begin : g_real
            assign tree_age[LEAVES + i] = slot_age_reg[i];
            assign tree_ok[LEAVES + i]  = 1'b1;
        end
        else
        begin : g_pad
            assign tree_age[LEAVES + i] = '0;
            assign tree_ok[LEAVES + i]  = 1'b0;
        end
        assign tree_idx[LEAVES + i] = SLOT_W'(i);
    end

    // one compare per node per cycle; the left child keeps ties
    always_ff @(posedge clk)
    begin
        for (int n = 1; n < LEAVES; n++)
        begin
            if (tree_ok[2*n+1] && (!tree_ok[2*n] || tree_age[2*n+1] > tree_age[2*n]))
            begin
                node_age_reg[n] <= tree_age[2*n+1];
                node_idx_reg[n] <= tree_idx[2*n+1];
            end
            else
            begin
                node_age_reg[n] <= tree_age[2*n];
                node_idx_reg[n] <= tree_idx[2*n];
            end
            node_ok_reg[n] <= tree_ok[2*n] | tree_ok[2*n+1];
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.res_oob)
        begin
            res_status_reg   <= ST_OOB;
            res_slot_reg     <= '0;
            res_wb_valid_reg <= 1'b0;
            res_wb_block_reg <= '0;
        end
        else if (cmd.res_find)
        begin
            res_status_reg   <= hit_any ? ST_OK : ST_MISS;
            res_slot_reg     <= hit_any ? hit_idx : '0;
            res_wb_valid_reg <= 1'b0;
            res_wb_block_reg <= '0;
        end
        else if (claim)
        begin
            res_status_reg   <= ST_OK;
            res_slot_reg     <= claim_idx;
            res_wb_valid_reg <= cmd.claim_victim & victim_dirty;
            res_wb_block_reg <= (cmd.claim_victim && victim_dirty) ?
                                slot_block_reg[root_idx] : '0;
        end
    end

    // response register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.push_rsp)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // response register payload
    always_ff @(posedge clk)
    begin
        if (cmd.push_rsp)
        begin
            rsp_status_reg   <= res_status_reg;
            rsp_slot_reg     <= res_slot_reg;
            rsp_wb_valid_reg <= res_wb_valid_reg;
            rsp_wb_block_reg <= res_wb_block_reg;
        end
    end

    assign rsp_valid           = rsp_valid_reg;
    assign rsp_status          = rsp_status_reg;
    assign rsp_slot_index      = rsp_slot_reg;
    assign rsp_writeback_valid = rsp_wb_valid_reg;
    assign rsp_writeback_block = rsp_wb_block_reg;

endmodule

[hdl/block_buffer_cache_manager_top.sv]
// lookup, set-dirty and out-of-bound requests: decoded in EXEC, response pushed from RESP
// allocate: ages in EXEC, claims a free slot, or in a full cache waits in SCAN for the
// SLOT_W-level victim tree and claims its oldest slot; one request in flight, the next
// taken while the response waits; an unknown kind is dropped without a response
// reset clears used, dirty and age flags at once; no clearing pass
// holds the top level; depends on bbcm_pkg, bbcm_if, bbcm_ctrl, bbcm_datapath
module block_buffer_cache_manager_top import bbcm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    bbcm_req_if.sink   req,
    bbcm_rsp_if.source rsp
);

    cmd_t cmd;
    sts_t sts;

    // controller
    bbcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath
    bbcm_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_kind            (req.kind),
        .req_block_num       (req.block_num),
        .cmd                 (cmd),
        .sts                 (sts),
        .rsp_ready           (rsp.ready),
        .rsp_valid           (rsp.valid),
        .rsp_status          (rsp.status),
        .rsp_slot_index      (rsp.slot_index),
        .rsp_writeback_valid (rsp.writeback_valid),
        .rsp_writeback_block (rsp.writeback_block)
    );

endmodule

[hdl/bbcm_checker.sv]
// port-level checks of the block buffer cache manager response channel
// depends on bbcm_pkg and block_buffer_cache_manager_top_defines.svh; bound to the top
`include "block_buffer_cache_manager_top_defines.svh"

module bbcm_checker import bbcm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [SLOT_W-1:0]   rsp_slot_index,
    input logic                rsp_writeback_valid,
    input logic [BLOCK_W-1:0]  rsp_writeback_block
);

    logic [STATUS_W+SLOT_W+BLOCK_W-1:0] rsp_payload;

    // payload fields that must hold while stalled
    assign rsp_payload = {rsp_status, rsp_slot_index, rsp_writeback_block};

    // a stalled response keeps its payload
    `BBCM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

    // failed requests report slot zero
    `BBCM_ASSERT_NOW(a_fail_slot_zero, rsp_valid && rsp_status != ST_OK, rsp_slot_index == '0)

    // a writeback only comes with a successful allocate
    `BBCM_ASSERT_NOW(a_wb_ok, rsp_valid && rsp_writeback_valid, rsp_status == ST_OK)

    // no writeback means a zero writeback block
    `BBCM_ASSERT_NOW(a_wb_block_zero, rsp_valid && !rsp_writeback_valid, rsp_writeback_block == '0)

endmodule

bind block_buffer_cache_manager_top bbcm_checker u_bbcm_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_slot_index      (rsp.slot_index),
    .rsp_writeback_valid (rsp.writeback_valid),
    .rsp_writeback_block (rsp.writeback_block)
);

[bench/tb.sv]
// self-checking bench for block_buffer_cache_manager_top: slot directory with oldest-age eviction
// depends on bbcm_pkg and bbcm_if from the hdl folder; a scoreboard class predicts each response
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bbcm_pkg::*;

    localparam int RANDOM_ITEMS  = 1800;
    localparam int POOL_SIZE     = 48;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;

    localparam logic [KIND_W-1:0] REQ_KINDS [3] = '{KIND_ALLOC, KIND_LOOKUP, KIND_DIRTY};

    // one response of the directory
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                wb_valid;
        logic [BLOCK_W-1:0]  wb_block;
    } dir_reply_t;

    // predicts directory responses and checks them in order
    class slot_dir_scoreboard;
        bit                 used [SLOT_COUNT];
        bit                 dirty [SLOT_COUNT];
        bit [AGE_BITS-1:0]  age [SLOT_COUNT];
        bit [BLOCK_W-1:0]   held_block [SLOT_COUNT];
        dir_reply_t         replies_due [$];
        int                 fault_count;

        function void report_fault(string msg);
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("%0t mismatch: %s", $realtime, msg);
        endfunction

        // update the directory copy for one accepted request
        function void note_request(logic [KIND_W-1:0] kind, logic [BLK_IN_W-1:0] blk);
            dir_reply_t r;
            int         pick;
            r    = '0;
            pick = -1;
            if (kind == KIND_NONE)
                return;
            if (blk >= DISK_BLOCK_COUNT)
                r.status = ST_OOB;
            else if (kind == KIND_ALLOC)
            begin
                // age every used slot, saturating
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (used[i] && age[i] != {AGE_BITS{1'b1}})
                        age[i] = age[i] + 1'b1;
                // lowest free slot first
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (pick < 0 && !used[i])
                        pick = i;
                // otherwise evict the oldest, lowest index on a tie
                if (pick < 0)
                begin
                    pick = 0;
                    for (int i = 1; i < SLOT_COUNT; i++)
                        if (age[i] > age[pick])
                            pick = i;
                    if (dirty[pick])
                    begin
                        r.wb_valid = 1'b1;
                        r.wb_block = held_block[pick];
                    end
                end
                used[pick]       = 1'b1;
                dirty[pick]      = 1'b0;
                age[pick]        = '0;
                held_block[pick] = blk[BLOCK_W-1:0];
                r.status         = ST_OK;
                r.slot           = SLOT_W'(pick);
            end
            else
            begin
                // lookup and set-dirty share the search
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (pick < 0 && used[i] && held_block[i] == blk[BLOCK_W-1:0])
                        pick = i;
                if (pick < 0)
                    r.status = ST_MISS;
                else
                begin
                    if (kind == KIND_DIRTY)
                        dirty[pick] = 1'b1;
                    r.status = ST_OK;
                    r.slot   = SLOT_W'(pick);
                end
            end
            replies_due.push_back(r);
        endfunction

        // compare one accepted response with the oldest prediction
        function void check_reply(dir_reply_t got);
            dir_reply_t want;
            if (replies_due.size() == 0)
            begin
                report_fault($sformatf("unexpected response status %0d slot %0d wb %0b block %0d",
                                       got.status, got.slot, got.wb_valid, got.wb_block));
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.wb_valid !== want.wb_valid || got.wb_block !== want.wb_block)
                report_fault($sformatf(
                    "status %0d/%0d slot %0d/%0d wb %0b/%0b block %0d/%0d (expected/actual)",
                    want.status, got.status, want.slot, got.slot,
                    want.wb_valid, got.wb_valid, want.wb_block, got.wb_block));
        endfunction

        // anything still waiting at the end is lost
        function void flag_leftovers();
            while (replies_due.size() != 0)
            begin
                void'(replies_due.pop_front());
                report_fault("response never arrived");
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bbcm_req_if req_ch ();
    bbcm_rsp_if rsp_ch ();

    block_buffer_cache_manager_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    slot_dir_scoreboard        sb;
    int                        items_sent;
    int                        burst_left;
    logic [BLOCK_W-1:0]        pool [POOL_SIZE];

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // offer one request and wait for its transaction, then idle between bursts
    task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [BLK_IN_W-1:0] blk);
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= kind;
        req_ch.block_num <= blk;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(kind, blk);
        items_sent++;
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            req_ch.valid <= 1'b0;
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(5, 20)) @(negedge clk);
            else
                repeat ($urandom_range(1, 4)) @(negedge clk);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(40, 80);
            else
                burst_left = $urandom_range(1, 10);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        int                  start_count;
        int                  choice;
        int                  extra;
        logic [BLOCK_W-1:0]  blk;
        sb               = new();
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.kind      = KIND_ALLOC;
        req_ch.block_num = '0;
        items_sent       = 0;
        burst_left       = $urandom_range(1, 10);
        foreach (pool[i])
            pool[i] = BLOCK_W'($urandom_range(0, DISK_BLOCK_COUNT - 1));
        pool[0] = '0;
        pool[1] = '1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty misses, extremes, out of bound, unknown kind, duplicates
        issue_request(KIND_LOOKUP, 16'd0);
        issue_request(KIND_DIRTY,  16'd0);
        issue_request(KIND_ALLOC,  16'd0);
        issue_request(KIND_ALLOC,  16'd8191);
        issue_request(KIND_ALLOC,  16'd8192);
        issue_request(KIND_LOOKUP, 16'hFFFF);
        issue_request(KIND_DIRTY,  16'hE000);
        issue_request(KIND_NONE,   16'h1234);
        issue_request(KIND_LOOKUP, 16'd8191);
        issue_request(KIND_DIRTY,  16'd8191);
        issue_request(KIND_DIRTY,  16'd0);
        issue_request(KIND_ALLOC,  16'd0);
        issue_request(KIND_LOOKUP, 16'd0);
        issue_request(KIND_NONE,   16'hFFFF);
        issue_request(KIND_ALLOC,  16'h1555);
        issue_request(KIND_ALLOC,  16'h0AAA);
        issue_request(KIND_LOOKUP, 16'h1555);

        // random: mostly allocate-then-use sequences over a small block pool
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            choice = $urandom_range(0, 9);
            blk    = pool[$urandom_range(0, POOL_SIZE - 1)];
            case (choice)
                0, 1, 2, 3, 4:
                begin
                    issue_request(KIND_ALLOC, BLK_IN_W'(blk));
                    extra = $urandom_range(0, 3);
                    repeat (extra)
                        issue_request($urandom_range(0, 1) ? KIND_DIRTY : KIND_LOOKUP,
                                      BLK_IN_W'(blk));
                end
                5, 6:
                    issue_request($urandom_range(0, 1) ? KIND_DIRTY : KIND_LOOKUP,
                                  BLK_IN_W'(blk));
                7:
                    issue_request(REQ_KINDS[$urandom_range(0, 2)],
                                  BLK_IN_W'($urandom_range(DISK_BLOCK_COUNT, 65535)));
                8:
                    issue_request(REQ_KINDS[$urandom_range(0, 2)],
                                  BLK_IN_W'($urandom_range(0, DISK_BLOCK_COUNT - 1)));
                default:
                    issue_request(KIND_NONE, BLK_IN_W'($urandom));
            endcase
        end

        // drain and settle
        req_ch.valid <= 1'b0;
        while (sb.replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.flag_leftovers();
        if (sb.fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // response ready: changing stall modes plus two long hold-offs
    initial
    begin
        int rx_cycle;
        int mode;
        rsp_ch.ready = 1'b0;
        rx_cycle     = 0;
        mode         = 0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle % 97 == 0)
                mode = $urandom_range(0, 3);
            if (rx_cycle == 2000 || rx_cycle == 12000)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_cycle += HOLD_CYCLES;
            end
            case (mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                2:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                default: rsp_ch.ready <= (rx_cycle % 4 != 0);
            endcase
        end
    end

    // response monitor
    initial
    begin
        dir_reply_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.status   = rsp_ch.status;
                got.slot     = rsp_ch.slot_index;
                got.wb_valid = rsp_ch.writeback_valid;
                got.wb_block = rsp_ch.writeback_block;
                sb.check_reply(got);
            end
        end
    end

    // timeout
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule

[block_buffer_cache_manager_top.f]
+incdir+hdl
hdl/bbcm_pkg.sv
hdl/bbcm_if.sv
hdl/bbcm_ctrl.sv
hdl/bbcm_datapath.sv
hdl/block_buffer_cache_manager_top.sv
hdl/bbcm_checker.sv
bench/tb.sv
